FILE: src/assert_macros.svh
// Assertion macros shared by the quaternion-to-Euler RTL.
// Clock and reset are taken as clk_i and rst_ni of the including module.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef NO_ASSERTIONS
`define Q2E_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);
`define Q2E_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) prop) else $error(msg);
`else
`define Q2E_ASSERT(lbl, prop, msg)
`define Q2E_ASSERT_ALWAYS(lbl, prop, msg)
`endif
`endif

FILE: src/q2e_pkg.sv
// Types, constants and the arctangent table of the quaternion-to-Euler block.
// No dependencies.
package q2e_pkg;

  localparam int VW      = 34;  // vector component width
  localparam int XW      = 36;  // CORDIC datapath width
  localparam int SW      = 32;  // arcsine argument width
  localparam int CW      = 31;  // square root width
  localparam int ATAN_LEN = 24;

  typedef struct packed {
    logic signed [VW-1:0] roll_y;
    logic signed [VW-1:0] roll_x;
    logic signed [VW-1:0] yaw_y;
    logic signed [VW-1:0] yaw_x;
    logic signed [SW-1:0] s;
    logic                 clamped;
  } vec_t;

  typedef struct packed {
    vec_t          v;
    logic [CW-1:0] c;
  } item_t;

  function automatic logic [31:0] atan_entry(input int k);
    logic [31:0] r;
    case (k)
      0:  r = 32'h20000000;
      1:  r = 32'h12E4051E;
      2:  r = 32'h09FB385B;
      3:  r = 32'h051111D4;
      4:  r = 32'h028B0D43;
      5:  r = 32'h0145D7E1;
      6:  r = 32'h00A2F61E;
      7:  r = 32'h00517C55;
      8:  r = 32'h0028BE53;
      9:  r = 32'h00145F2F;
      10: r = 32'h000A2F98;
      11: r = 32'h000517CC;
      12: r = 32'h00028BE6;
      13: r = 32'h000145F3;
      14: r = 32'h0000A2FA;
      15: r = 32'h0000517D;
      16: r = 32'h000028BE;
      17: r = 32'h0000145F;
      18: r = 32'h00000A30;
      19: r = 32'h00000518;
      20: r = 32'h0000028C;
      21: r = 32'h00000146;
      22: r = 32'h000000A3;
      23: r = 32'h00000051;
      default: r = 32'h0;
    endcase
    return r;
  endfunction

endpackage

FILE: src/q2e_front.sv
// Front pipeline: pairwise products, sums, arcsine clamp and a
// pipelined integer square root. Depends on q2e_pkg.
module q2e_front (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_ready_o,
  input  logic [63:0]         in_data_i,
  output logic                out_valid_o,
  input  logic                out_ready_i,
  output q2e_pkg::item_t      out_item_o
);
  localparam int SQ_STEPS = 32;
  localparam int NST      = SQ_STEPS + 3;
  localparam int VW       = q2e_pkg::VW;
  localparam int SW       = q2e_pkg::SW;

  logic [NST-1:0] vld_q;
  logic           en;

  logic signed [15:0] qw, qx, qy, qz;
  logic signed [31:0] ww_q, wx_q, wy_q, wz_q, xx_q, xy_q, xz_q, yy_q, yz_q, zz_q;
  q2e_pkg::vec_t      vec1_d, vec1_q;
  logic signed [VW-1:0] s_raw;
  logic signed [63:0] sq;

  q2e_pkg::vec_t vec_q [0:SQ_STEPS];
  logic [63:0]   rv_q  [0:SQ_STEPS];
  logic [63:0]   rr_q  [0:SQ_STEPS];

  assign en         = !vld_q[NST-1] || out_ready_i;
  assign in_ready_o = en;
  assign qw = in_data_i[15:0];
  assign qx = in_data_i[31:16];
  assign qy = in_data_i[47:32];
  assign qz = in_data_i[63:48];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (en) begin
      vld_q <= {vld_q[NST-2:0], in_valid_i};
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      ww_q <= 32'(qw) * 32'(qw);
      wx_q <= 32'(qw) * 32'(qx);
      wy_q <= 32'(qw) * 32'(qy);
      wz_q <= 32'(qw) * 32'(qz);
      xx_q <= 32'(qx) * 32'(qx);
      xy_q <= 32'(qx) * 32'(qy);
      xz_q <= 32'(qx) * 32'(qz);
      yy_q <= 32'(qy) * 32'(qy);
      yz_q <= 32'(qy) * 32'(qz);
      zz_q <= 32'(qz) * 32'(qz);
    end
  end

  always_comb begin
    vec1_d.roll_x = VW'(ww_q) - VW'(xx_q) - VW'(yy_q) + VW'(zz_q);
    vec1_d.roll_y = (VW'(yz_q) + VW'(wx_q)) <<< 1;
    vec1_d.yaw_x  = VW'(ww_q) + VW'(xx_q) - VW'(yy_q) - VW'(zz_q);
    vec1_d.yaw_y  = (VW'(xy_q) + VW'(wz_q)) <<< 1;
    s_raw         = (VW'(wy_q) - VW'(xz_q)) <<< 1;
    vec1_d.clamped = 1'b0;
    vec1_d.s       = SW'(s_raw);
    if (s_raw > (VW'(1) <<< 30)) begin
      vec1_d.s       = SW'(1) <<< 30;
      vec1_d.clamped = 1'b1;
    end else if (s_raw < -(VW'(1) <<< 30)) begin
      vec1_d.s       = -(SW'(1) <<< 30);
      vec1_d.clamped = 1'b1;
    end
  end

  assign sq = 64'(vec1_q.s) * 64'(vec1_q.s);

  always_ff @(posedge clk_i) begin
    if (en) begin
      vec1_q    <= vec1_d;
      vec_q[0]  <= vec1_q;
      rv_q[0]   <= (64'(1) << 60) - sq;
      rr_q[0]   <= '0;
    end
  end

  for (genvar j = 0; j < SQ_STEPS; j++) begin : g_sqrt
    localparam logic [63:0] BIT = 64'(1) << (62 - 2 * j);
    logic [63:0] t, v_d, r_d;
    always_comb begin
      t = rr_q[j] + BIT;
      if (rv_q[j] >= t) begin
        v_d = rv_q[j] - t;
        r_d = (rr_q[j] >> 1) + BIT;
      end else begin
        v_d = rv_q[j];
        r_d = rr_q[j] >> 1;
      end
    end
    always_ff @(posedge clk_i) begin
      if (en) begin
        vec_q[j+1] <= vec_q[j];
        rv_q[j+1]  <= v_d;
        rr_q[j+1]  <= r_d;
      end
    end
  end

  assign out_valid_o  = vld_q[NST-1];
  assign out_item_o.v = vec_q[SQ_STEPS];
  assign out_item_o.c = rr_q[SQ_STEPS][q2e_pkg::CW-1:0];

endmodule

FILE: src/q2e_fifo.sv
// Two-entry queue between front and back pipelines.
// Depends on q2e_pkg and assert_macros.svh.
`include "assert_macros.svh"
module q2e_fifo (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           push_valid_i,
  output logic           push_ready_o,
  input  q2e_pkg::item_t push_item_i,
  output logic           pop_valid_o,
  input  logic           pop_ready_i,
  output q2e_pkg::item_t pop_item_o
);
  q2e_pkg::item_t mem_q [0:1];
  logic       wr_q, rd_q;
  logic [1:0] cnt_q;
  logic       push, pop;

  assign push_ready_o = (cnt_q != 2'd2);
  assign pop_valid_o  = (cnt_q != 2'd0);
  assign push = push_valid_i && push_ready_o;
  assign pop  = pop_valid_o && pop_ready_i;
  assign pop_item_o = mem_q[rd_q];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= 1'b0;
      rd_q  <= 1'b0;
      cnt_q <= 2'd0;
    end else begin
      if (push) wr_q <= !wr_q;
      if (pop) rd_q <= !rd_q;
      cnt_q <= cnt_q + 2'(push) - 2'(pop);
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) mem_q[wr_q] <= push_item_i;
  end

  `Q2E_ASSERT(a_cnt_max, cnt_q != 2'd3, "queue count overflow")
  `Q2E_ASSERT(a_ptr_cnt, (cnt_q == 2'd1) |-> (wr_q != rd_q), "queue pointers disagree")
  `Q2E_ASSERT(a_cnt_step, (push && !pop) |=> (cnt_q == $past(cnt_q) + 2'd1), "count step")

endmodule

FILE: src/q2e_cordic.sv
// Unrolled vectoring CORDIC, one iteration per stage, returning a rounded
// 16-bit binary angle. Depends on q2e_pkg.
module q2e_cordic #(
  parameter int STEPS = 16
) (
  input  logic                            clk_i,
  input  logic                            en_i,
  input  logic signed [q2e_pkg::VW-1:0]   y_i,
  input  logic signed [q2e_pkg::VW-1:0]   x_i,
  output logic signed [15:0]              angle_o
);
  localparam int XW = q2e_pkg::XW;

  logic signed [XW-1:0] x_q [0:STEPS];
  logic signed [XW-1:0] y_q [0:STEPS];
  logic [31:0]          acc_q [0:STEPS];
  logic                 zero_q [0:STEPS];
  logic [31:0]          rnd;

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      zero_q[0] <= (x_i == '0) && (y_i == '0);
      if (x_i < 0) begin
        x_q[0]   <= -XW'(x_i);
        y_q[0]   <= -XW'(y_i);
        acc_q[0] <= 32'h80000000;
      end else begin
        x_q[0]   <= XW'(x_i);
        y_q[0]   <= XW'(y_i);
        acc_q[0] <= '0;
      end
    end
  end

  for (genvar k = 0; k < STEPS; k++) begin : g_it
    logic signed [XW-1:0] dx, dy;
    assign dx = y_q[k] >>> k;
    assign dy = x_q[k] >>> k;
    always_ff @(posedge clk_i) begin
      if (en_i) begin
        zero_q[k+1] <= zero_q[k];
        if (!y_q[k][XW-1]) begin
          x_q[k+1]   <= x_q[k] + dx;
          y_q[k+1]   <= y_q[k] - dy;
          acc_q[k+1] <= acc_q[k] + q2e_pkg::atan_entry(k);
        end else begin
          x_q[k+1]   <= x_q[k] - dx;
          y_q[k+1]   <= y_q[k] + dy;
          acc_q[k+1] <= acc_q[k] - q2e_pkg::atan_entry(k);
        end
      end
    end
  end

  assign rnd     = acc_q[STEPS] + 32'h8000;
  assign angle_o = zero_q[STEPS] ? 16'sd0 : $signed(rnd[31:16]);

endmodule

FILE: src/q2e_back.sv
// Back pipeline: three CORDIC units, pitch saturation and output register.
// Depends on q2e_pkg and q2e_cordic.
module q2e_back #(
  parameter int STEPS = 16
) (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           in_valid_i,
  output logic           in_ready_o,
  input  q2e_pkg::item_t in_item_i,
  output logic           out_valid_o,
  input  logic           out_ready_i,
  output logic [47:0]    out_data_o,
  output logic           out_flag_o
);
  localparam int VW = q2e_pkg::VW;

  logic               en;
  logic [STEPS:0]     vld_q;
  logic [STEPS:0]     clp_q;
  logic signed [15:0] roll, pitch, yaw, pitch_sat;
  logic               out_valid_q, out_flag_q;
  logic [47:0]        out_data_q;

  assign en         = !out_valid_q || out_ready_i;
  assign in_ready_o = en;

  q2e_cordic #(.STEPS(STEPS)) u_roll (
    .clk_i(clk_i), .en_i(en),
    .y_i(in_item_i.v.roll_y), .x_i(in_item_i.v.roll_x), .angle_o(roll));
  q2e_cordic #(.STEPS(STEPS)) u_pitch (
    .clk_i(clk_i), .en_i(en),
    .y_i(VW'(in_item_i.v.s)), .x_i(VW'({1'b0, in_item_i.c})), .angle_o(pitch));
  q2e_cordic #(.STEPS(STEPS)) u_yaw (
    .clk_i(clk_i), .en_i(en),
    .y_i(in_item_i.v.yaw_y), .x_i(in_item_i.v.yaw_x), .angle_o(yaw));

  always_comb begin
    pitch_sat = pitch;
    if (pitch > 16'sd16384) pitch_sat = 16'sd16384;
    if (pitch < -16'sd16384) pitch_sat = -16'sd16384;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q       <= '0;
      out_valid_q <= 1'b0;
    end else if (en) begin
      vld_q       <= {vld_q[STEPS-1:0], in_valid_i};
      out_valid_q <= vld_q[STEPS];
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      clp_q      <= {clp_q[STEPS-1:0], in_item_i.v.clamped};
      out_flag_q <= clp_q[STEPS];
      out_data_q <= {yaw, pitch_sat, roll};
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_data_q;
  assign out_flag_o  = out_flag_q;

endmodule

FILE: src/quaternion_to_euler_top.sv
// Quaternion to Z-Y-X Euler angles, top level.
// Depends on q2e_pkg, q2e_front, q2e_fifo, q2e_back, assert_macros.svh.
//
// channel  | dir | fields
// s_axis   | in  | tdata: quat_w[15:0] quat_x[31:16] quat_y[47:32] quat_z[63:48]
// m_axis   | out | tdata: roll[15:0] pitch[31:16] yaw[47:32]; tuser: pitch_clamped
//
// One item per cycle unless a side stalls. Items pass 35 front stages
// (products, sums, 32-stage square root), the queue and N+2 back stages,
// with N = min(CORDIC_STEPS, 24). Reset clears all valid state; no clearing pass.
// Front and back stall separately; the queue holds two items.
`include "assert_macros.svh"
module quaternion_to_euler_top #(
  parameter int CORDIC_STEPS = 16
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [63:0] s_axis_tdata,   // quat_w, quat_x, quat_y, quat_z
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [47:0] m_axis_tdata,   // roll, pitch, yaw
  output logic        m_axis_tuser    // pitch_clamped
);
  localparam int N = (CORDIC_STEPS > q2e_pkg::ATAN_LEN) ? q2e_pkg::ATAN_LEN : CORDIC_STEPS;

  logic           f_valid, f_ready, b_valid, b_ready;
  q2e_pkg::item_t f_item, b_item;

  q2e_front u_front (
    .clk_i(clk_i), .rst_ni(rst_ni),
    .in_valid_i(s_axis_tvalid), .in_ready_o(s_axis_tready), .in_data_i(s_axis_tdata),
    .out_valid_o(f_valid), .out_ready_i(f_ready), .out_item_o(f_item));

  q2e_fifo u_fifo (
    .clk_i(clk_i), .rst_ni(rst_ni),
    .push_valid_i(f_valid), .push_ready_o(f_ready), .push_item_i(f_item),
    .pop_valid_o(b_valid), .pop_ready_i(b_ready), .pop_item_o(b_item));

  q2e_back #(.STEPS(N)) u_back (
    .clk_i(clk_i), .rst_ni(rst_ni),
    .in_valid_i(b_valid), .in_ready_o(b_ready), .in_item_i(b_item),
    .out_valid_o(m_axis_tvalid), .out_ready_i(m_axis_tready),
    .out_data_o(m_axis_tdata), .out_flag_o(m_axis_tuser));

  `Q2E_ASSERT(a_pitch_hi, m_axis_tvalid |-> ($signed(m_axis_tdata[31:16]) <= 16'sd16384), "pitch high")
  `Q2E_ASSERT(a_pitch_lo, m_axis_tvalid |-> ($signed(m_axis_tdata[31:16]) >= -16'sd16384), "pitch low")
  `Q2E_ASSERT(a_clamp_src, (b_valid && b_ready && b_item.v.clamped) |-> (b_item.c == '0), "clamped root")

endmodule
